[sv/els_pkg.sv]
// shared types, codes and constants for the elf load extent scanner
package els_pkg;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned FLEN_W    = 31;
    localparam int unsigned CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_ADDR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_BAD_SEG       = 2'd1;
    localparam logic [1:0] ST_NO_EXTENT     = 2'd2;
    localparam logic [1:0] ST_ENTRY_OUTSIDE = 2'd3;

    // recorded error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BAD_SEG = 2'd1;

    localparam logic [31:0]       LOADABLE_TYPE = 32'h0000_0001;
    localparam logic [ADDR_W-1:0] ALL_ONES      = '1;

    typedef struct packed {
        logic [31:0]       seg_type;
        logic [31:0]       seg_file_offset;
        logic [ADDR_W-1:0] seg_vaddr;
        logic [31:0]       seg_file_size;
        logic [31:0]       seg_mem_size;
        logic [31:0]       seg_flags;
        logic              last_header;
    } seg_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] low_addr;
        logic [ADDR_W-1:0] high_addr;
        logic              any_found;
        logic [1:0]        first_error;
    } scan_state_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] base_addr;
        logic [ADDR_W-1:0] extent_size;
        logic [ADDR_W-1:0] entry_delta;
    } scan_result_t;

    localparam scan_state_t SCAN_CLEAR = '{
        low_addr:    ALL_ONES,
        high_addr:   '0,
        any_found:   1'b0,
        first_error: ERR_NONE
    };

endpackage

[sv/els_update.sv]
// per-header extent update and end-of-image result evaluation
module els_update (
    input  els_pkg::seg_item_t             item,
    input  els_pkg::scan_state_t           cur,
    input  logic [els_pkg::ADDR_W-1:0]     entry_addr,
    input  logic [els_pkg::FLEN_W-1:0]     file_length,
    output els_pkg::scan_state_t           nxt,
    output els_pkg::scan_result_t          result
);
    import els_pkg::*;

    logic [ADDR_W-1:0] seg_end;
    logic [32:0]       file_end;
    logic              packed_hdr;
    logic              bad_seg;
    scan_state_t       upd;
    logic [1:0]        status;

    assign seg_end  = item.seg_vaddr + item.seg_mem_size;
    assign file_end = {1'b0, item.seg_file_offset} + {1'b0, item.seg_file_size};

    assign packed_hdr = (item.seg_type == LOADABLE_TYPE) && (item.seg_mem_size != '0) &&
                        ((item.seg_flags[1:0] != 2'b00) ||
                         ((entry_addr >= item.seg_vaddr) && (entry_addr < seg_end)));

    assign bad_seg = (item.seg_file_size > item.seg_mem_size) ||
                     (file_end > {2'b00, file_length});

    always_comb
    begin
        upd = cur;
        if ((cur.first_error == ERR_NONE) && packed_hdr)
        begin
            if (bad_seg)
            begin
                upd.first_error = ERR_BAD_SEG;
            end
            else
            begin
                if (!cur.any_found || (item.seg_vaddr < cur.low_addr))
                    upd.low_addr = item.seg_vaddr;
                if (!cur.any_found || (seg_end > cur.high_addr))
                    upd.high_addr = seg_end;
                upd.any_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (upd.first_error != ERR_NONE)
            status = ST_BAD_SEG;
        else if (!upd.any_found || (upd.high_addr <= upd.low_addr))
            status = ST_NO_EXTENT;
        else if ((entry_addr < upd.low_addr) || (entry_addr >= upd.high_addr))
            status = ST_ENTRY_OUTSIDE;
        else
            status = ST_OK;
    end

    always_comb
    begin
        result.status      = status;
        result.base_addr   = '0;
        result.extent_size = '0;
        result.entry_delta = '0;
        if (status == ST_OK)
        begin
            result.base_addr   = upd.low_addr;
            result.extent_size = upd.high_addr - upd.low_addr;
            result.entry_delta = entry_addr - upd.low_addr;
        end
    end

    // the last header of an image starts the next one from scratch
    assign nxt = item.last_header ? SCAN_CLEAR : upd;

endmodule

[sv/elf_load_extent_scanner_core.sv]
// top level of the elf load extent scanner: input register, scan state, result register
// a result is loaded into the result register when the last header of an image leaves the input register
// throughput: one header per cycle while no result waits on out_stall, limited by the single update pass in els_update
// headers that are not last produce no result beat
// reset: rst_n clears both pipeline valids, the scan state and the config registers
// while a result waits on out_stall the input register takes one more beat, then stalls
module elf_load_extent_scanner_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] seg_type,
    input  logic [31:0] seg_file_offset,
    input  logic [31:0] seg_vaddr,
    input  logic [31:0] seg_file_size,
    input  logic [31:0] seg_mem_size,
    input  logic [31:0] seg_flags,
    input  logic        last_header,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] base_addr,
    output logic [31:0] extent_size,
    output logic [31:0] entry_delta,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [els_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import els_pkg::*;

    logic [ADDR_W-1:0] entry_addr_reg;
    logic [FLEN_W-1:0] file_length_reg;

    logic         s1_valid_reg;
    seg_item_t    s1_item_reg;
    scan_state_t  scan_reg;
    scan_state_t  scan_next;
    scan_result_t res_next;
    scan_result_t res_reg;
    logic         out_valid_reg;

    logic out_free;
    logic s1_fire;
    logic in_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_addr_reg  <= '0;
            file_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENTRY_ADDR:  entry_addr_reg  <= cfg_data;
                CFG_FILE_LENGTH: file_length_reg <= cfg_data[FLEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // result register can take a new beat when empty or draining this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.seg_type        <= seg_type;
            s1_item_reg.seg_file_offset <= seg_file_offset;
            s1_item_reg.seg_vaddr       <= seg_vaddr;
            s1_item_reg.seg_file_size   <= seg_file_size;
            s1_item_reg.seg_mem_size    <= seg_mem_size;
            s1_item_reg.seg_flags       <= seg_flags;
            s1_item_reg.last_header     <= last_header;
        end
    end

    els_update u_update (
        .item        (s1_item_reg),
        .cur         (scan_reg),
        .entry_addr  (entry_addr_reg),
        .file_length (file_length_reg),
        .nxt         (scan_next),
        .result      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_reg <= SCAN_CLEAR;
        else if (s1_fire)
            scan_reg <= scan_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_item_reg.last_header)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_item_reg.last_header)
            res_reg <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign base_addr   = res_reg.base_addr;
    assign extent_size = res_reg.extent_size;
    assign entry_delta = res_reg.entry_delta;

    // a last header always leaves a clean scan state behind
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_item_reg.last_header) |=>
            (scan_reg.low_addr == ALL_ONES && scan_reg.high_addr == '0 &&
             !scan_reg.any_found && scan_reg.first_error == ERR_NONE))
        else $error("scan state not cleared after last header");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status != ST_OK) |->
            (res_reg.base_addr == '0 && res_reg.extent_size == '0 &&
             res_reg.entry_delta == '0))
        else $error("result fields nonzero on failing status");

    a_ok_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status == ST_OK) |-> (res_reg.extent_size != '0))
        else $error("ok status with empty image");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with no held beat");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// testbench for the elf load extent scanner: directed headers, then random images vs a scan model
module tb_top;
    import els_pkg::*;

    localparam int          LATENCY    = 2;
    localparam logic [31:0] FLAG_EXEC  = 32'h1;
    localparam logic [31:0] FLAG_WRITE = 32'h2;
    localparam logic [30:0] FLEN_MAX   = '1;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [31:0]           reg_data;
        seg_item_t             hdr;
        bit                    known;
        scan_result_t          known_res;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [31:0]          seg_type = '0;
    logic [31:0]          seg_file_offset = '0;
    logic [31:0]          seg_vaddr = '0;
    logic [31:0]          seg_file_size = '0;
    logic [31:0]          seg_mem_size = '0;
    logic [31:0]          seg_flags = '0;
    logic                 last_header = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [31:0]          base_addr;
    logic [31:0]          extent_size;
    logic [31:0]          entry_delta;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // scan model state and its copy of the registers
    scan_state_t  scan = SCAN_CLEAR;
    logic [31:0]  entry_reg = '0;
    logic [30:0]  flen_reg = '0;

    scan_result_t image_reports_q[$];
    dir_row_t     dir_rows[$];
    int           mismatch_count = 0;
    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;

    elf_load_extent_scanner_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .seg_type        (seg_type),
        .seg_file_offset (seg_file_offset),
        .seg_vaddr       (seg_vaddr),
        .seg_file_size   (seg_file_size),
        .seg_mem_size    (seg_mem_size),
        .seg_flags       (seg_flags),
        .last_header     (last_header),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .base_addr       (base_addr),
        .extent_size     (extent_size),
        .entry_delta     (entry_delta),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // folds one header into the running extent, returns the image report on a last header
    function automatic scan_result_t fold_header(input seg_item_t h, output bit reported);
        logic [31:0]  seg_end;
        logic [32:0]  file_end;
        bit           packed_hdr;
        scan_result_t res;
        seg_end  = h.seg_vaddr + h.seg_mem_size;
        file_end = {1'b0, h.seg_file_offset} + {1'b0, h.seg_file_size};
        packed_hdr = (h.seg_type == LOADABLE_TYPE) && (h.seg_mem_size != 0) &&
                     (((h.seg_flags & (FLAG_EXEC | FLAG_WRITE)) != 0) ||
                      (entry_reg >= h.seg_vaddr && entry_reg < seg_end));
        if (scan.first_error == ERR_NONE && packed_hdr)
        begin
            if (h.seg_file_size > h.seg_mem_size || file_end > {2'b00, flen_reg})
                scan.first_error = ERR_BAD_SEG;
            else
            begin
                if (!scan.any_found || h.seg_vaddr < scan.low_addr)
                    scan.low_addr = h.seg_vaddr;
                if (!scan.any_found || seg_end > scan.high_addr)
                    scan.high_addr = seg_end;
                scan.any_found = 1'b1;
            end
        end
        res = '0;
        reported = h.last_header;
        if (!h.last_header)
            return res;
        if (scan.first_error != ERR_NONE)
            res.status = ST_BAD_SEG;
        else if (!scan.any_found || scan.high_addr <= scan.low_addr)
            res.status = ST_NO_EXTENT;
        else if (entry_reg < scan.low_addr || entry_reg >= scan.high_addr)
            res.status = ST_ENTRY_OUTSIDE;
        else
        begin
            res.status      = ST_OK;
            res.base_addr   = scan.low_addr;
            res.extent_size = scan.high_addr - scan.low_addr;
            res.entry_delta = entry_reg - scan.low_addr;
        end
        scan = SCAN_CLEAR;
        return res;
    endfunction

    function automatic dir_row_t hdr_row(input logic [31:0] t, input logic [31:0] foff,
                                         input logic [31:0] va, input logic [31:0] fsz,
                                         input logic [31:0] msz, input logic [31:0] fl,
                                         input bit last);
        dir_row_t r;
        r = '{default: '0};
        r.hdr.seg_type        = t;
        r.hdr.seg_file_offset = foff;
        r.hdr.seg_vaddr       = va;
        r.hdr.seg_file_size   = fsz;
        r.hdr.seg_mem_size    = msz;
        r.hdr.seg_flags       = fl;
        r.hdr.last_header     = last;
        return r;
    endfunction

    // last header whose report is obvious from the spec
    function automatic dir_row_t known_row(input logic [31:0] t, input logic [31:0] foff,
                                           input logic [31:0] va, input logic [31:0] fsz,
                                           input logic [31:0] msz, input logic [31:0] fl,
                                           input logic [1:0] st, input logic [31:0] base,
                                           input logic [31:0] size, input logic [31:0] off);
        dir_row_t r;
        r = hdr_row(t, foff, va, fsz, msz, fl, 1'b1);
        r.known     = 1'b1;
        r.known_res = '{st, base, size, off};
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [31:0] data);
        dir_row_t r;
        r = '{default: '0};
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    // mostly plausible headers around the entry address, some pure noise
    function automatic seg_item_t random_header(input bit last);
        seg_item_t h;
        h.seg_type        = $urandom;
        h.seg_file_offset = $urandom;
        h.seg_vaddr       = $urandom;
        h.seg_file_size   = $urandom;
        h.seg_mem_size    = $urandom;
        h.seg_flags       = $urandom;
        h.last_header     = last;
        if ($urandom_range(0, 9) == 0)
            return h;
        if ($urandom_range(0, 11) != 0)
            h.seg_type = LOADABLE_TYPE;
        if ($urandom_range(0, 30) == 0)
            h.seg_mem_size = '0;
        else if ($urandom_range(0, 20) != 0)
            h.seg_mem_size = $urandom_range(1, 32'h4000);
        h.seg_vaddr = entry_reg + $urandom_range(0, 32'hC000) - 32'h6000;
        if ($urandom_range(0, 39) == 0)
            h.seg_file_size = h.seg_mem_size + 1;
        else
            h.seg_file_size = $urandom_range(0, h.seg_mem_size);
        if (h.seg_file_size <= {1'b0, flen_reg})
        begin
            if ($urandom_range(0, 39) == 0)
                h.seg_file_offset = flen_reg - h.seg_file_size + 1 + $urandom_range(0, 15);
            else
                h.seg_file_offset = $urandom_range(0, flen_reg - h.seg_file_size);
        end
        if ($urandom_range(0, 3) == 0)
            h.seg_flags[1:0] = 2'b00;
        return h;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (image_reports_q.size() == 0)
            begin
                $display("%0t ns: unexpected report, expected none, actual %0d %h %h %h",
                         $time, status, base_addr, extent_size, entry_delta);
                mismatch_count++;
            end
            else
            begin
                want = image_reports_q.pop_front();
                compare_field("status", 32'(want.status), 32'(status));
                compare_field("base_addr", want.base_addr, base_addr);
                compare_field("extent_size", want.extent_size, extent_size);
                compare_field("entry_delta", want.entry_delta, entry_delta);
            end
        end
    end

    task automatic send_header(input seg_item_t h, input bit known,
                               input scan_result_t known_res);
        scan_result_t res;
        bit           reported;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        seg_type        <= h.seg_type;
        seg_file_offset <= h.seg_file_offset;
        seg_vaddr       <= h.seg_vaddr;
        seg_file_size   <= h.seg_file_size;
        seg_mem_size    <= h.seg_mem_size;
        seg_flags       <= h.seg_flags;
        last_header     <= h.last_header;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = fold_header(h, reported);
        if (reported)
            image_reports_q.push_back(known ? known_res : res);
    endtask

    // stop sending until all reports are back, optionally let the pipe run empty
    task automatic settle(input bit full);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (image_reports_q.size() != 0);
        if (full)
            repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_ENTRY_ADDR)
            entry_reg = data;
        else if (idx == CFG_FILE_LENGTH)
            flen_reg = data[30:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int gap_pct, input int stall_pct, input int n_items);
        int          sent;
        int          images;
        int          n;
        logic [31:0] pick;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        sent   = 0;
        images = 0;
        while (sent < n_items)
        begin
            if (images % 40 == 0)
            begin
                settle(1'b1);
                pick = $urandom;
                if ($urandom_range(0, 7) == 0)
                    pick = '0;
                else if ($urandom_range(0, 7) == 0)
                    pick = ALL_ONES;
                set_reg(CFG_ENTRY_ADDR, pick);
                case ($urandom_range(0, 7))
                    0:       pick = {1'b0, FLEN_MAX};
                    1:       pick = $urandom_range(0, 32'hFFFF);
                    default: pick = $urandom_range(32'h1_0000, 32'h7FFF_FFFF);
                endcase
                set_reg(CFG_FILE_LENGTH, pick);
            end
            if (images == 25)
                settle(1'b0);
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_header(random_header(i == n - 1), 1'b0, '0);
            sent += n;
            images++;
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int waited;
        // reset values of the registers: entry 0, file length 0
        dir_rows.push_back(known_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h10, 32'h3,
                                     ST_NO_EXTENT, 32'h0, 32'h0, 32'h0));
        dir_rows.push_back(known_row(LOADABLE_TYPE, 32'h0, 32'h0, 32'h0, 32'h100, FLAG_WRITE,
                                     ST_OK, 32'h0, 32'h100, 32'h0));
        dir_rows.push_back(reg_row(CFG_ENTRY_ADDR, 32'h1000));
        dir_rows.push_back(reg_row(CFG_FILE_LENGTH, {1'b0, FLEN_MAX}));
        // two-header image, file data ending exactly at the file length
        dir_rows.push_back(hdr_row(LOADABLE_TYPE, 32'h100, 32'h1000, 32'h2000, 32'h2000,
                                   FLAG_EXEC, 1'b0));
        dir_rows.push_back(known_row(LOADABLE_TYPE, 32'h7FFF_FFFF, 32'h800, 32'h0, 32'h100,
                                     FLAG_WRITE, ST_OK, 32'h800, 32'h2800, 32'h800));
        // file size above memory size
        dir_rows.push_back(known_row(LOADABLE_TYPE, 32'h0, 32'h0, 32'h11, 32'h10, 32'h3,
                                     ST_BAD_SEG, 32'h0, 32'h0, 32'h0));
        // offset plus size past the file without wrap, later headers ignored
        dir_rows.push_back(hdr_row(LOADABLE_TYPE, 32'hFFFF_FFFF, 32'h1000, 32'h1, 32'h1,
                                   FLAG_EXEC, 1'b0));
        dir_rows.push_back(hdr_row(LOADABLE_TYPE, 32'h0, 32'h1000, 32'h0, 32'h10,
                                   FLAG_EXEC, 1'b0));
        dir_rows.push_back(known_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                     ST_BAD_SEG, 32'h0, 32'h0, 32'h0));
        // zero memory size is never packed
        dir_rows.push_back(known_row(LOADABLE_TYPE, 32'h0, 32'h1000, 32'h0, 32'h0, 32'h3,
                                     ST_NO_EXTENT, 32'h0, 32'h0, 32'h0));
        // no permission bits: packed only when the entry lies inside
        dir_rows.push_back(known_row(LOADABLE_TYPE, 32'h0, 32'hF00, 32'h200, 32'h200,
                                     32'hFFFF_FFFC, ST_OK, 32'hF00, 32'h200, 32'h100));
        dir_rows.push_back(known_row(LOADABLE_TYPE, 32'h0, 32'h2000, 32'h0, 32'h10,
                                     32'hFFFF_FFFC, ST_NO_EXTENT, 32'h0, 32'h0, 32'h0));
        // segment end wraps below its start
        dir_rows.push_back(hdr_row(LOADABLE_TYPE, 32'h0, 32'hFFFF_F000, 32'h0, 32'h2000,
                                   FLAG_WRITE, 1'b1));
        dir_rows.push_back(known_row(LOADABLE_TYPE, 32'h0, 32'h4000, 32'h0, 32'h100,
                                     FLAG_EXEC, ST_ENTRY_OUTSIDE, 32'h0, 32'h0, 32'h0));
        // entry at the end, then at the start
        dir_rows.push_back(hdr_row(LOADABLE_TYPE, 32'h0, 32'hF00, 32'h0, 32'h100,
                                   FLAG_EXEC, 1'b1));
        dir_rows.push_back(known_row(LOADABLE_TYPE, 32'h0, 32'h1000, 32'h0, 32'h1,
                                     FLAG_WRITE, ST_OK, 32'h1000, 32'h1, 32'h0));
        dir_rows.push_back(known_row('1, '1, '1, '1, '1, '1,
                                     ST_NO_EXTENT, 32'h0, 32'h0, 32'h0));
        dir_rows.push_back(known_row(LOADABLE_TYPE, '1, '1, '1, '1, '1,
                                     ST_BAD_SEG, 32'h0, 32'h0, 32'h0));
        dir_rows.push_back(reg_row(CFG_ENTRY_ADDR, ALL_ONES));
        dir_rows.push_back(reg_row(CFG_FILE_LENGTH, 32'h0));
        dir_rows.push_back(hdr_row(LOADABLE_TYPE, 32'h0, 32'hFFFF_FF00, 32'h0, 32'hFF,
                                   32'h0, 1'b1));
        dir_rows.push_back(hdr_row(LOADABLE_TYPE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
                                   FLAG_WRITE, 1'b1));
        dir_rows.push_back(hdr_row(LOADABLE_TYPE, 32'h0, 32'h0, 32'h1, 32'h1,
                                   FLAG_EXEC, 1'b1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 21;
        recv_stall_pct = 74;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_write)
            begin
                settle(1'b1);
                set_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            end
            else
                send_header(dir_rows[i].hdr, dir_rows[i].known, dir_rows[i].known_res);
        end

        run_phase(21, 74, 430);
        run_phase(74, 21, 430);
        run_phase(0, 0, 430);

        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (image_reports_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (image_reports_q.size() != 0)
        begin
            $display("%0t ns: %0d expected reports never arrived", $time,
                     image_reports_q.size());
            mismatch_count += image_reports_q.size();
        end
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
sv/els_pkg.sv
sv/els_update.sv
sv/elf_load_extent_scanner_core.sv
tb/tb_top.sv
